// ----- rtl/aip_pkg.sv -----
// Shared types, codes and character constants for the ASCII integer parser.
`default_nettype none

package aip_pkg;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 64;
	localparam int NLIM_W   = 63;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;
	localparam int SDATA_W  = 8;
	localparam int MDATA_W  = 72;
	// accumulator times sixteen plus one digit
	localparam int PROD_W   = VALUE_W + 4;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEG_LIMIT   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_ARG = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	typedef struct packed {
		logic              signed_mode;
		logic [VALUE_W-1:0] pos_limit;
		logic [NLIM_W-1:0]  neg_limit;
	} cfg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_byte;
		logic              last_byte;
		logic              empty_string;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic is_hex;
		logic [3:0] val;
	} digit_t;

	// Decode one character as a hex digit.
	function automatic digit_t hex_digit(input logic [CHAR_W-1:0] c);
		digit_t d;
		logic [CHAR_W-1:0] t;
		d.is_hex = 1'b0;
		d.val    = 4'd0;
		t        = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			d.is_hex = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			d.is_hex = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			d.is_hex = 1'b1;
		end
		d.val = t[3:0];
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aip_cfg.sv -----
// Configuration registers of the ASCII integer parser.
`default_nettype none

module aip_cfg
	import aip_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signed_mode <= 1'b1;
			cfg_q.pos_limit   <= 64'd2147483647;
			cfg_q.neg_limit   <= 63'd2147483648;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIGNED_MODE: cfg_q.signed_mode <= cfg_wdata[0];
				CFG_POS_LIMIT:   cfg_q.pos_limit   <= cfg_wdata;
				CFG_NEG_LIMIT:   cfg_q.neg_limit   <= cfg_wdata[NLIM_W-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/aip_in_stage.sv -----
// Input register stage: holds one accepted character until the parser takes it.
`default_nettype none

module aip_in_stage
	import aip_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       s1_valid,
	output item_t      s1_item,
	input  wire logic  s1_adv
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

`default_nettype wire

// ----- rtl/aip_engine.sv -----
// Parse engine: per-character state update, overflow check and final result.
`default_nettype none

module aip_engine
	import aip_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  s1_valid,
	input  wire item_t s1_item,
	input  wire logic  out_free,
	output logic       s1_adv,
	output logic       res_load,
	output result_t    res
);

	typedef enum logic [2:0] {
		PH_LEAD     = 3'd0,
		PH_PREFIX   = 3'd1,
		PH_ZERO     = 3'd2,
		PH_DIGITS   = 3'd3,
		PH_HEXSTART = 3'd4,
		PH_TRAIL    = 3'd5
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic               neg_q, neg_n;
	logic               hex_q, hex_n;
	status_t            err_q, err_n;

	logic [CHAR_W-1:0]  c;
	digit_t             dig;
	logic               run_digit;
	logic [VALUE_W-1:0] limit;
	logic [PROD_W-1:0]  prod;
	logic               ovf;
	logic               emit;
	status_t            fin_status;

	assign c   = s1_item.char_byte;
	assign dig = hex_digit(c);

	// acc * base + d against the limit is the cutoff/cutlim test done exactly
	assign limit = neg_q ? {1'b0, cfg.neg_limit} : cfg.pos_limit;
	assign prod  = hex_q ? ({acc_q, 4'b0000} + {{(PROD_W-4){1'b0}}, dig.val})
	                     : ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
	                        + {{(PROD_W-4){1'b0}}, dig.val});
	assign ovf   = prod > {{(PROD_W-VALUE_W){1'b0}}, limit};

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		hex_n     = hex_q;
		err_n     = err_q;
		run_digit = 1'b0;
		if (err_q == ST_OK) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (c == CH_SPACE) begin
						phase_n = PH_LEAD;
					end else if (c == CH_MINUS) begin
						if (cfg.signed_mode) begin
							neg_n   = 1'b1;
							phase_n = PH_PREFIX;
						end else begin
							err_n = ST_ARG;
						end
					end else if (c == CH_PLUS) begin
						phase_n = PH_PREFIX;
					end else if (c == CH_ZERO) begin
						phase_n = PH_ZERO;
					end else begin
						run_digit = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (c == CH_ZERO) phase_n = PH_ZERO;
					else run_digit = 1'b1;
				end
				PH_ZERO: begin
					if (c == CH_X_LO || c == CH_X_UP) begin
						hex_n   = 1'b1;
						phase_n = PH_HEXSTART;
					end else begin
						run_digit = 1'b1;
					end
				end
				PH_HEXSTART, PH_DIGITS: run_digit = 1'b1;
				default: begin
					if (c != CH_SPACE) err_n = ST_ARG;
				end
			endcase
			if (run_digit) begin
				phase_n = PH_DIGITS;
				if (!dig.is_hex) begin
					// digit run ends here; only spaces may follow
					phase_n = PH_TRAIL;
					if (c != CH_SPACE) err_n = ST_ARG;
				end else if (!hex_q && dig.val > 4'd9) begin
					err_n = ST_ARG;
				end else if (ovf) begin
					err_n = ST_OVF;
				end else begin
					acc_n = prod[VALUE_W-1:0];
				end
			end
		end
	end

	always_comb begin
		fin_status = err_n;
		if (err_n == ST_OK &&
		    (phase_n == PH_LEAD || phase_n == PH_PREFIX || phase_n == PH_HEXSTART)) begin
			fin_status = ST_ARG;
		end
		res.status = fin_status;
		res.value  = '0;
		if (s1_item.empty_string) begin
			res.status = ST_ARG;
		end else if (fin_status == ST_OK) begin
			res.value = neg_n ? (~acc_n + 64'd1) : acc_n;
		end
	end

	assign emit     = s1_item.empty_string || s1_item.last_byte;
	assign s1_adv   = s1_valid && (!emit || out_free);
	assign res_load = s1_adv && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			hex_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (s1_adv) begin
			if (emit) begin
				// string done: start fresh for the next one
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				hex_q   <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				hex_q   <= hex_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aip_out_stage.sv -----
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module aip_out_stage
	import aip_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_load,
	input  wire result_t res,
	output logic         out_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

// ----- rtl/ascii_integer_parser_core.sv -----
// Top level of the ASCII integer parser.
// Parses a string of ASCII characters, one per transfer, as a decimal or 0x-prefixed
// hex integer with leading spaces, an optional sign and trailing spaces, checking each
// digit against the configured limit. One character is taken every clock cycle unless
// a last character waits for the result register to free; the rate is set by the digit
// step (shift-add accumulate and a 68-bit compare against the limit). The result of a
// string reaches m_tdata through the input register, which captures its last character
// (or empty-string marker), and then the result register, which captures the result.
// Write configuration only while no string is in flight.
`default_nettype none

module ascii_integer_parser_core
	import aip_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [SDATA_W-1:0]   s_tdata,   // [7:0] char_byte
	input  wire logic                 s_tlast,   // last_byte
	input  wire logic                 s_tuser,   // empty_string
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [MDATA_W-1:0]        m_tdata,   // [1:0] status, [65:2] value, rest zero
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   in_item;
	item_t   s1_item;
	logic    s1_valid;
	logic    s1_adv;
	logic    out_free;
	logic    res_load;
	result_t res;
	result_t out_res;

	assign in_item.char_byte    = s_tdata;
	assign in_item.last_byte    = s_tlast;
	assign in_item.empty_string = s_tuser;

	aip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aip_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.s1_valid (s1_valid),
		.s1_item  (s1_item),
		.s1_adv   (s1_adv)
	);

	aip_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s1_valid (s1_valid),
		.s1_item  (s1_item),
		.out_free (out_free),
		.s1_adv   (s1_adv),
		.res_load (res_load),
		.res      (res)
	);

	aip_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(MDATA_W-VALUE_W-2){1'b0}}, out_res};

endmodule

`default_nettype wire
